[rtl/pts_pkg.sv]
// Shared constants and types for the priority task scheduler.
// No dependencies; every other file of the block but pts_ram imports this package.
package pts_pkg;

    localparam int NUM_TASKS_DEF    = 8;
    localparam int COUNTER_BITS_DEF = 16;

    localparam int CMD_W   = 1;
    localparam int SLOT_W  = 3;
    localparam int FIELD_W = 16;
    localparam int TASK_W  = 3;

    localparam logic [CMD_W-1:0] CMD_TICK = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b1;

    typedef enum logic [1:0] {
        ALU_GE     = 2'd0,
        ALU_DEC    = 2'd1,
        ALU_REFILL = 2'd2
    } t_alu_op;

endpackage

[rtl/pts_in_if.sv]
// Input channel of the scheduler: one word is a tick or a task load.
// Depends on pts_pkg for the field widths.
interface pts_in_if;
    import pts_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  task_slot;
    logic [FIELD_W-1:0] load_counter;
    logic [FIELD_W-1:0] load_priority;
    logic               load_runnable;

    modport source (
        output valid, command, task_slot, load_counter, load_priority, load_runnable,
        input  ready
    );
    modport sink (
        input  valid, command, task_slot, load_counter, load_priority, load_runnable,
        output ready
    );
endinterface

[rtl/pts_out_if.sv]
// Output channel of the scheduler: one word per tick with the chosen task.
// Depends on pts_pkg for the field widths.
interface pts_out_if;
    import pts_pkg::*;

    logic               valid;
    logic               ready;
    logic               switched;
    logic [TASK_W-1:0]  running_task;
    logic [FIELD_W-1:0] running_counter;
    logic               no_task;

    modport source (
        output valid, switched, running_task, running_counter, no_task,
        input  ready
    );
    modport sink (
        input  valid, switched, running_task, running_counter, no_task,
        output ready
    );
endinterface

[rtl/pts_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/pts_alu.sv]
// Shared arithmetic unit of the scheduler: compare, saturating decrement
// and saturating refill. Depends on pts_pkg for the operation codes.
module pts_alu #(
    parameter int WIDTH = 16
) (
    input  pts_pkg::t_alu_op  i_op,
    input  logic [WIDTH-1:0]  i_a,
    input  logic [WIDTH-1:0]  i_b,
    output logic [WIDTH-1:0]  o_res,
    output logic              o_flag
);
    import pts_pkg::*;

    logic [WIDTH:0] sum;

    assign sum = {1'b0, (i_a >> 1)} + {1'b0, i_b};

    always_comb begin
        unique case (i_op)
            ALU_GE: begin
                o_res  = i_a;
                o_flag = (i_a >= i_b);
            end
            ALU_DEC: begin
                o_res  = (i_a == '0) ? '0 : (i_a - WIDTH'(1));
                o_flag = (i_a <= WIDTH'(1));
            end
            ALU_REFILL: begin
                o_res  = sum[WIDTH] ? '1 : sum[WIDTH-1:0];
                o_flag = 1'b0;
            end
            default: begin
                o_res  = '0;
                o_flag = 1'b0;
            end
        endcase
    end
endmodule

[rtl/priority_task_scheduler.sv]
// Priority task scheduler: sequencer, task tables in RAM and one shared ALU.
// Depends on pts_pkg, pts_in_if, pts_out_if, pts_ram and pts_alu.
//
//   port     dir  modport  carries
//   i_task   in   sink     tick or load of one task (counter, priority, runnable)
//   o_res    out  source   one word per tick: switched, task, counter, no_task
//
// Loads are written in the idle state. A tick that keeps the task passes the
// decrement and output states; one that schedules scans the tables, after a
// decrement or from the idle task, adding a refill pass and rescan when the
// first scan finds no nonzero counter, one table read per cycle. A finished
// word waits in the sequencer while the output register is full and unread.
// Reset clears the valid bits and the sequencer; entries never loaded read as
// zero. A finished word waits in the output register while loads go on.
module priority_task_scheduler #(
    parameter int NUM_TASKS    = pts_pkg::NUM_TASKS_DEF,
    parameter int COUNTER_BITS = pts_pkg::COUNTER_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pts_in_if.sink     i_task,
    pts_out_if.source  o_res
);
    import pts_pkg::*;

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = COUNTER_BITS;
    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_TASKS - 1);
    localparam logic [IW-1:0] FIRST_IDX = IW'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DEC    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_REFILL = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state                r_state;
    logic [IW-1:0]         r_cur;
    logic [IW-1:0]         r_iss;
    logic                  r_iss_on;
    logic                  r_dv;
    logic [IW-1:0]         r_rd_addr;
    logic                  r_pass;
    logic [CW-1:0]         r_max;
    logic [IW-1:0]         r_choice;
    logic                  r_none;
    logic [NUM_TASKS-1:0]  r_valid;
    logic                  r_ov;
    logic                  r_o_switched;
    logic [TASK_W-1:0]     r_o_task;
    logic [FIELD_W-1:0]    r_o_counter;
    logic                  r_o_none;

    logic                  in_fire;
    logic                  is_load;
    logic                  slot_ok;
    logic [IW-1:0]         slot_idx;
    logic [IW-1:0]         raddr;
    logic                  issue;
    logic                  cnt_we;
    logic [IW-1:0]         cnt_waddr;
    logic [CW-1:0]         cnt_wdata;
    logic [CW-1:0]         cnt_q;
    logic [CW:0]           prio_q;
    logic [CW-1:0]         cnt_rd;
    logic [CW-1:0]         prio_rd;
    logic                  run_rd;
    t_alu_op               alu_op;
    logic [CW-1:0]         alu_b;
    logic [CW-1:0]         alu_res;
    logic                  alu_flag;
    logic                  take;
    logic                  last;
    logic [CW-1:0]         n_max;
    logic [IW-1:0]         n_choice;
    logic                  out_free;

    assign i_task.ready = (r_state == S_IDLE);
    assign in_fire      = i_task.valid && i_task.ready;
    assign is_load      = (i_task.command == CMD_LOAD);
    assign slot_ok      = (i_task.task_slot != '0) && (int'(i_task.task_slot) < NUM_TASKS);
    assign slot_idx     = IW'(i_task.task_slot);

    assign raddr = (r_state == S_IDLE) ? r_cur : r_iss;
    assign issue = r_iss_on && ((r_state == S_SCAN) || (r_state == S_REFILL));

    assign cnt_rd  = r_valid[r_rd_addr] ? cnt_q : '0;
    assign prio_rd = r_valid[r_rd_addr] ? prio_q[CW-1:0] : '0;
    assign run_rd  = r_valid[r_rd_addr] && prio_q[CW];

    always_comb begin
        priority case (1'b1)
            (r_state == S_DEC): begin
                alu_op = ALU_DEC;
                alu_b  = r_max;
            end
            (r_state == S_REFILL): begin
                alu_op = ALU_REFILL;
                alu_b  = prio_rd;
            end
            default: begin
                alu_op = ALU_GE;
                alu_b  = r_max;
            end
        endcase
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_rd_addr;
        cnt_wdata = alu_res;
        if (in_fire && is_load && slot_ok) begin
            cnt_we    = 1'b1;
            cnt_waddr = slot_idx;
            cnt_wdata = CW'(i_task.load_counter);
        end else if (r_state == S_DEC) begin
            cnt_we = 1'b1;
        end else if ((r_state == S_REFILL) && r_dv) begin
            cnt_we = 1'b1;
        end
    end

    pts_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_TASKS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (raddr),
        .o_rdata (cnt_q)
    );

    pts_ram #(
        .WIDTH (CW + 1),
        .DEPTH (NUM_TASKS)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && is_load && slot_ok),
        .i_waddr (slot_idx),
        .i_wdata ({i_task.load_runnable, CW'(i_task.load_priority)}),
        .i_raddr (raddr),
        .o_rdata (prio_q)
    );

    pts_alu #(
        .WIDTH (CW)
    ) u_alu (
        .i_op   (alu_op),
        .i_a    (cnt_rd),
        .i_b    (alu_b),
        .o_res  (alu_res),
        .o_flag (alu_flag)
    );

    // The first entry of the first pass seeds the maximum unconditionally.
    assign take     = r_dv && (((!r_pass) && (r_rd_addr == FIRST_IDX)) || (run_rd && alu_flag));
    assign last     = r_dv && (r_rd_addr == LAST_IDX);
    assign n_max    = take ? cnt_rd : r_max;
    assign n_choice = take ? r_rd_addr : r_choice;
    assign out_free = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_iss    <= '0;
            r_iss_on <= 1'b0;
            r_dv     <= 1'b0;
            r_pass   <= 1'b0;
            r_valid  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_dv <= issue;
            if (issue) begin
                r_iss <= r_iss + IW'(1);
                if (r_iss == LAST_IDX) begin
                    r_iss_on <= 1'b0;
                end
            end
            if (r_ov && o_res.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (is_load) begin
                            if (slot_ok) begin
                                r_valid[slot_idx] <= 1'b1;
                            end
                        end else if (r_cur == '0) begin
                            r_state  <= S_SCAN;
                            r_pass   <= 1'b0;
                            r_iss    <= FIRST_IDX;
                            r_iss_on <= 1'b1;
                        end else begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    if (!alu_flag) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state  <= S_SCAN;
                        r_pass   <= 1'b0;
                        r_iss    <= FIRST_IDX;
                        r_iss_on <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (last) begin
                        if (n_max != '0) begin
                            r_state <= S_OUT;
                        end else if (!r_pass) begin
                            r_state  <= S_REFILL;
                            r_pass   <= 1'b1;
                            r_iss    <= FIRST_IDX;
                            r_iss_on <= 1'b1;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_REFILL: begin
                    if (last) begin
                        r_state  <= S_SCAN;
                        r_iss    <= FIRST_IDX;
                        r_iss_on <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_cur   <= r_choice;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= raddr;
        if (r_state == S_DEC) begin
            r_choice <= r_cur;
            r_max    <= alu_res;
            r_none   <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_max    <= n_max;
            if (last && (n_max == '0) && r_pass) begin
                r_choice <= '0;
                r_none   <= 1'b1;
            end else begin
                r_choice <= n_choice;
                r_none   <= 1'b0;
            end
        end
        if ((r_state == S_OUT) && out_free) begin
            r_o_switched <= (r_choice != r_cur);
            r_o_task     <= TASK_W'(r_choice);
            r_o_counter  <= FIELD_W'(r_max);
            r_o_none     <= r_none;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.switched        = r_o_switched;
    assign o_res.running_task    = r_o_task;
    assign o_res.running_counter = r_o_counter;
    assign o_res.no_task         = r_o_none;

    // The idle slot is never written, so its counter stays zero.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (cnt_waddr != '0))
        else $error("counter table written at the idle slot");

    // A chosen ordinary task always has a nonzero counter; the idle task has zero.
    a_choice_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ((r_choice == '0) == (r_max == '0)))
        else $error("chosen task and its counter disagree");

    a_none_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_none) |-> (r_choice == '0))
        else $error("no_task raised with an ordinary task chosen");

    a_data_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> ((r_state == S_SCAN) || (r_state == S_REFILL)))
        else $error("table read data arrived outside a scan or refill pass");

    a_word_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=> (r_ov && (r_state == S_IDLE)))
        else $error("finished word not placed in the output register");
endmodule

[tb/sv/pts_sched_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the priority task scheduler: mirrors the task tables and predicts each tick.
// Depends on pts_pkg, pts_in_if and pts_out_if. It only watches the channels.
module pts_sched_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pts_in_if    i_task_mon,
    pts_out_if   i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import pts_pkg::*;

    localparam int NT = NUM_TASKS_DEF;
    localparam int CW = COUNTER_BITS_DEF;

    typedef struct packed {
        logic               switched;
        logic [TASK_W-1:0]  running_task;
        logic [FIELD_W-1:0] running_counter;
        logic               no_task;
    } t_sched_word;

    logic [CW-1:0]     slice_cnt [NT];
    logic [CW-1:0]     prio_val [NT];
    logic              run_mark [NT];
    logic [TASK_W-1:0] cur_task;
    t_sched_word       sched_q[$];
    int                fails = 0;

    function automatic void scan_tasks(inout logic [CW-1:0] best,
                                       inout logic [TASK_W-1:0] choice);
        int i;
        for (i = 1; i < NT; i++) begin
            if (run_mark[i] && slice_cnt[i] >= best) begin
                best   = slice_cnt[i];
                choice = TASK_W'(i);
            end
        end
    endfunction

    function automatic logic pick_task(output logic [TASK_W-1:0] choice);
        logic [CW-1:0] best;
        logic [CW:0]   sum;
        int            i;
        best   = slice_cnt[1];
        choice = TASK_W'(1);
        scan_tasks(best, choice);
        if (best != '0) return 1'b1;
        for (i = 1; i < NT; i++) begin
            sum = {1'b0, slice_cnt[i] >> 1} + {1'b0, prio_val[i]};
            slice_cnt[i] = sum[CW] ? '1 : sum[CW-1:0];
        end
        scan_tasks(best, choice);
        return best != '0;
    endfunction

    task automatic predict_tick();
        logic [TASK_W-1:0] prev_task;
        logic [TASK_W-1:0] next_task;
        logic [TASK_W-1:0] choice;
        logic              none;
        logic              sched;
        t_sched_word       word;
        prev_task = cur_task;
        next_task = prev_task;
        none      = 1'b0;
        sched     = 1'b0;
        if (prev_task == '0) begin
            sched = 1'b1;
        end else begin
            if (slice_cnt[prev_task] != '0) slice_cnt[prev_task] = slice_cnt[prev_task] - 1'b1;
            sched = (slice_cnt[prev_task] == '0);
        end
        if (sched) begin
            if (pick_task(choice)) begin
                next_task = choice;
            end else begin
                next_task = '0;
                none      = 1'b1;
            end
        end
        cur_task             = next_task;
        word.switched        = (next_task != prev_task);
        word.running_task    = next_task;
        word.running_counter = FIELD_W'(slice_cnt[next_task]);
        word.no_task         = none;
        sched_q.push_back(word);
    endtask

    task automatic note_failure(input string what, input t_sched_word want,
                                input t_sched_word got);
        fails++;
        if (fails <= 10) begin
            $display({"%0t: %s: expected sw=%0b task=%0d cnt=%0d none=%0b, ",
                      "got sw=%0b task=%0d cnt=%0d none=%0b"},
                     $realtime, what, want.switched, want.running_task, want.running_counter,
                     want.no_task, got.switched, got.running_task, got.running_counter,
                     got.no_task);
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_word got;
        t_sched_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) begin
                slice_cnt[i] = '0;
                prio_val[i]  = '0;
                run_mark[i]  = 1'b0;
            end
            cur_task = '0;
            sched_q.delete();
        end else begin
            if (i_task_mon.valid && i_task_mon.ready) begin
                if (i_task_mon.command == CMD_LOAD) begin
                    if (i_task_mon.task_slot != '0 && int'(i_task_mon.task_slot) < NT) begin
                        slice_cnt[i_task_mon.task_slot] = CW'(i_task_mon.load_counter);
                        prio_val[i_task_mon.task_slot]  = CW'(i_task_mon.load_priority);
                        run_mark[i_task_mon.task_slot]  = i_task_mon.load_runnable;
                    end
                end else begin
                    predict_tick();
                end
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.switched        = i_res_mon.switched;
                got.running_task    = i_res_mon.running_task;
                got.running_counter = i_res_mon.running_counter;
                got.no_task         = i_res_mon.no_task;
                if (sched_q.size() == 0) begin
                    note_failure("word with nothing pending", '0, got);
                end else begin
                    want = sched_q.pop_front();
                    if (got.switched !== want.switched
                            || got.running_task !== want.running_task
                            || got.running_counter !== want.running_counter
                            || got.no_task !== want.no_task) begin
                        note_failure("mismatch", want, got);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= sched_q.size();
    end

endmodule

[tb/sv/tb_priority_task_scheduler.sv]
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, stimulus, output stalls and the verdict.
// Depends on pts_pkg, both channel interfaces, the block and pts_sched_checker.
module tb_priority_task_scheduler;
    import pts_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet;
    int   loaded_items;

    pts_in_if  task_ch ();
    pts_out_if res_ch ();

    priority_task_scheduler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (task_ch),
        .o_res   (res_ch)
    );

    pts_sched_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_mon   (task_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [FIELD_W-1:0] rand_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return FIELD_W'($urandom_range(0, 6));
        if (r < 9) return FIELD_W'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic [FIELD_W-1:0] cnt, input logic [FIELD_W-1:0] pri,
                             input logic run);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            task_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        task_ch.valid         <= 1'b1;
        task_ch.command       <= cmd;
        task_ch.task_slot     <= slot;
        task_ch.load_counter  <= cnt;
        task_ch.load_priority <= pri;
        task_ch.load_runnable <= run;
        do @(posedge i_clk); while (!task_ch.ready);
    endtask

    task automatic load_task(input logic [SLOT_W-1:0] slot, input logic [FIELD_W-1:0] cnt,
                             input logic [FIELD_W-1:0] pri, input logic run);
        send_word(CMD_LOAD, slot, cnt, pri, run);
    endtask

    task automatic tick();
        send_word(CMD_TICK, SLOT_W'($urandom_range(0, 7)), rand_field(), rand_field(),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic drain_results();
        task_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // Output side: stall a random number of cycles before taking each word.
    initial begin
        int stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    initial begin
        int                  r;
        logic [SLOT_W-1:0]   slot;
        quiet                 = 1'b0;
        loaded_items          = 0;
        i_rst_n              <= 1'b0;
        task_ch.valid        <= 1'b0;
        task_ch.command      <= CMD_TICK;
        task_ch.task_slot    <= '0;
        task_ch.load_counter <= '0;
        task_ch.load_priority <= '0;
        task_ch.load_runnable <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing loaded: the schedule finds no task.
        tick();
        // A load to the idle slot changes nothing.
        load_task(3'd0, 16'd9, 16'd9, 1'b1);
        tick();
        // Task 1 is not runnable but holds the largest counter, so it is still chosen.
        load_task(3'd1, 16'd100, 16'd3, 1'b0);
        load_task(3'd2, 16'd50, 16'd1, 1'b1);
        load_task(3'd3, 16'd50, 16'd7, 1'b1);
        tick();
        tick();
        // Task 1 runs out; the tie between tasks 2 and 3 goes to the later one.
        load_task(3'd1, 16'd1, 16'd0, 1'b0);
        tick();
        // All runnable counters empty: refill with saturation, then rescan.
        load_task(3'd3, 16'd1, 16'hFFFF, 1'b1);
        load_task(3'd2, 16'd0, 16'hFFFF, 1'b1);
        load_task(3'd4, 16'hFFFF, 16'hFFFF, 1'b0);
        load_task(3'd7, 16'd0, 16'd1, 1'b1);
        tick();
        // The running task keeps its slice even when marked not runnable.
        load_task(3'd3, 16'hFFFF, 16'd0, 1'b0);
        tick();
        load_task(3'd3, 16'd0, 16'd0, 1'b0);
        tick();
        tick();
        load_task(3'd5, 16'd2, 16'd0, 1'b1);
        load_task(3'd6, 16'd2, 16'd0, 1'b1);
        tick();
        tick();
        tick();

        while (loaded_items < 400) begin
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            if (loaded_items == 200) drain_results();
            r = $urandom_range(0, 99);
            if (r < 35) begin
                slot = ($urandom_range(0, 15) == 0) ? '0 : SLOT_W'($urandom_range(1, 7));
                load_task(slot, rand_field(), rand_field(), $urandom_range(0, 9) < 8);
                if (slot != '0) loaded_items++;
            end else begin
                tick();
                loaded_items++;
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/pts_pkg.sv
rtl/pts_in_if.sv
rtl/pts_out_if.sv
rtl/pts_ram.sv
rtl/pts_alu.sv
rtl/priority_task_scheduler.sv
tb/sv/pts_sched_checker.sv
tb/sv/tb_priority_task_scheduler.sv
